/* rtl/crcfr_pkg.sv */
// Package for the CRC-16 message framer: queue entry types, CRC constants
// and the default payload limit. Used by every file of the framer.
`timescale 1ns / 1ps

package crcfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEFAULT = 244;
    localparam int unsigned QUEUE_DEPTH         = 6;
    localparam int unsigned CNT_W               = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // What a queued entry turns into when it reaches the output register.
    typedef enum logic [1:0] {
        TAG_FIRST  = 2'd0,  // first header byte, restarts the CRC
        TAG_DATA   = 2'd1,  // ordinary frame byte, folded into the CRC
        TAG_CRC_LO = 2'd2,  // low byte of the finished CRC
        TAG_CRC_HI = 2'd3   // high byte of the finished CRC, ends the frame
    } t_tag;

    typedef struct packed {
        t_tag       tag;
        logic [7:0] data;
    } t_entry;

endpackage

/* rtl/crcfr_crc_byte.sv */
// Byte-wide CRC-16 update, polynomial 0x1021, MSB first, no reflection.
// Depends on crcfr_pkg for the polynomial constants.
`timescale 1ns / 1ps

module crcfr_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & crcfr_pkg::CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

/* rtl/crc16_message_framer_top.sv */
// Top level of the CRC-16 message framer: frame bookkeeping, the byte queue
// and the output register. Depends on crcfr_pkg and crcfr_crc_byte.
//
// The first byte caused by an item passes through the byte queue and then the
// output register. Throughput: one frame byte per cycle while the output does
// not stall; a new item is taken as the last queued byte of the one before it
// moves on. A payload item causes 1 or 3 bytes, a start item 4 or 6, and an
// ignored payload item none; the output register sets this rate.
// Reset (synchronous, active low) closes any frame, empties the queue and the
// output register, clears the CRC and sets host_id to 1.
`timescale 1ns / 1ps

module crc16_message_framer_top #(
    parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // Configuration: host_id register.
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,

    // Input item channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_recipient,
    input  logic [7:0] i_command_code,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_payload_byte,

    // Result item channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end
);

    localparam int unsigned DEPTH = crcfr_pkg::QUEUE_DEPTH;
    localparam int unsigned CW    = crcfr_pkg::CNT_W;
    localparam logic [7:0]  MAX_LEN = 8'(MAX_PAYLOAD);

    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [CW-1:0] CNT_PAY   = CW'(1);
    localparam logic [CW-1:0] CNT_LAST  = CW'(3);
    localparam logic [CW-1:0] CNT_HDR   = CW'(4);
    localparam logic [CW-1:0] CNT_EMPTY = CW'(6);

    // Frame bookkeeping on the input side.
    logic [7:0] r_host;
    logic       r_frame_open, n_frame_open;
    logic [7:0] r_rem,        n_rem;

    // Byte queue. Entries are loaded in parallel when an item is accepted and
    // leave from the head into the output register, one per cycle when it is free.
    crcfr_pkg::t_entry r_q [DEPTH];
    crcfr_pkg::t_entry n_q [DEPTH];
    logic [CW-1:0]     r_cnt, n_cnt;

    // Output register and the CRC of the bytes that have passed through it.
    logic        r_ov,  n_ov;
    logic [7:0]  r_ob,  n_ob;
    logic        r_oe,  n_oe;
    logic [15:0] r_crc, n_crc;

    logic        out_free;
    logic        load;
    logic        in_acc;
    logic [7:0]  len_sat;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;

    crcfr_pkg::t_entry head;

    assign head     = r_q[0];
    // The output register can take a byte when it is empty or being emptied.
    assign out_free = !r_ov || !i_stall;
    assign load     = (r_cnt != '0) && out_free;
    // A new item is taken only when the queue will be empty after this edge.
    assign o_stall  = !((r_cnt == '0) || ((r_cnt == CNT_ONE) && out_free));
    assign in_acc   = i_valid && !o_stall;
    assign len_sat  = (i_payload_length > MAX_LEN) ? MAX_LEN : i_payload_length;

    // The first header byte restarts the CRC from zero.
    assign crc_base = (head.tag == crcfr_pkg::TAG_FIRST) ? 16'h0000 : r_crc;

    crcfr_crc_byte u_crc (
        .i_crc  (crc_base),
        .i_byte (head.data),
        .o_crc  (crc_upd)
    );

    // Output register and CRC.
    always_comb begin
        n_ov  = r_ov;
        n_ob  = r_ob;
        n_oe  = r_oe;
        n_crc = r_crc;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        if (load) begin
            n_ov = 1'b1;
            n_oe = 1'b0;
            case (head.tag)
                crcfr_pkg::TAG_FIRST, crcfr_pkg::TAG_DATA: begin
                    n_ob  = head.data;
                    n_crc = crc_upd;
                end
                crcfr_pkg::TAG_CRC_LO: begin
                    n_ob = r_crc[7:0];
                end
                crcfr_pkg::TAG_CRC_HI: begin
                    n_ob = r_crc[15:8];
                    n_oe = 1'b1;
                end
                default: begin
                    n_ob = head.data;
                end
            endcase
        end
    end

    // Queue and frame bookkeeping.
    always_comb begin
        n_q          = r_q;
        n_cnt        = r_cnt;
        n_frame_open = r_frame_open;
        n_rem        = r_rem;
        if (load) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            n_cnt = r_cnt - CNT_ONE;
        end
        if (in_acc) begin
            if (!i_kind) begin
                // Start item: a frame still open is dropped without its CRC.
                n_q[0] = '{tag: crcfr_pkg::TAG_FIRST,  data: i_recipient};
                n_q[1] = '{tag: crcfr_pkg::TAG_DATA,   data: len_sat};
                n_q[2] = '{tag: crcfr_pkg::TAG_DATA,   data: r_host};
                n_q[3] = '{tag: crcfr_pkg::TAG_DATA,   data: i_command_code};
                n_q[4] = '{tag: crcfr_pkg::TAG_CRC_LO, data: 8'h00};
                n_q[5] = '{tag: crcfr_pkg::TAG_CRC_HI, data: 8'h00};
                n_rem  = len_sat;
                if (len_sat == 8'h00) begin
                    n_cnt        = CNT_EMPTY;
                    n_frame_open = 1'b0;
                end else begin
                    n_cnt        = CNT_HDR;
                    n_frame_open = 1'b1;
                end
            end else if (r_frame_open) begin
                n_q[0] = '{tag: crcfr_pkg::TAG_DATA,   data: i_payload_byte};
                n_q[1] = '{tag: crcfr_pkg::TAG_CRC_LO, data: 8'h00};
                n_q[2] = '{tag: crcfr_pkg::TAG_CRC_HI, data: 8'h00};
                if (r_rem <= 8'h01) begin
                    n_cnt        = CNT_LAST;
                    n_rem        = 8'h00;
                    n_frame_open = 1'b0;
                end else begin
                    n_cnt = CNT_PAY;
                    n_rem = r_rem - 8'h01;
                end
            end
            // A payload item with no open frame is taken and dropped.
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host       <= 8'h01;
            r_frame_open <= 1'b0;
            r_rem        <= 8'h00;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
            r_crc        <= 16'h0000;
        end else begin
            if (i_cfg_wr_en) begin
                r_host <= i_cfg_wr_data;
            end
            r_frame_open <= n_frame_open;
            r_rem        <= n_rem;
            r_cnt        <= n_cnt;
            r_ov         <= n_ov;
            r_crc        <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q  <= n_q;
        r_ob <= n_ob;
        r_oe <= n_oe;
    end

    assign o_valid      = r_ov;
    assign o_frame_byte = r_ob;
    assign o_frame_end  = r_oe;

    // The queue never holds more entries than one start item produces.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_EMPTY)
        else $error("byte queue count out of range");

    // An item is never taken while more than one queued byte remains.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CNT_ONE) |-> o_stall)
        else $error("input accepted over a busy queue");

    // A start item always leaves a full header, with or without the CRC.
    a_start_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_kind) |=> ((r_cnt == CNT_HDR) || (r_cnt == CNT_EMPTY)))
        else $error("start item did not queue its header");

    // An open frame always still expects at least one payload byte.
    a_open_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_rem != 8'h00))
        else $error("open frame with no bytes remaining");

endmodule
